>>> rtl/lupiv_pkg.sv
// lupiv_pkg: shared types, operation codes and constants for the lu pivoting unit
// no dependencies; imported by the controller, datapath, divider and top level
package lupiv_pkg;

  // default largest matrix size and reset value of the size register
  localparam int MAX_SIZE_DEF = 8;
  localparam logic [3:0] SIZE_RESET = 4'd8;

  // one in q16.16
  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

  // divider: 32-bit magnitude shifted up by 16 fraction bits
  localparam int DIV_W = 48;
  localparam int DIV_CW = 6;

  // datapath operation codes
  typedef logic [3:0] op_t;
  localparam op_t OP_NOP      = 4'd0;
  localparam op_t OP_LOAD     = 4'd1;
  localparam op_t OP_CLEAR    = 4'd2;
  localparam op_t OP_READ     = 4'd3;
  localparam op_t OP_SWAP_A   = 4'd4;
  localparam op_t OP_SWAP_B   = 4'd5;
  localparam op_t OP_PIVOT    = 4'd6;
  localparam op_t OP_DIV      = 4'd7;
  localparam op_t OP_WR_MULT  = 4'd8;
  localparam op_t OP_WR_ZERO  = 4'd9;
  localparam op_t OP_SET_SING = 4'd10;
  localparam op_t OP_MUL      = 4'd11;
  localparam op_t OP_UPD      = 4'd12;
  localparam op_t OP_EMIT     = 4'd13;

  // controller to datapath command
  typedef struct packed {
    op_t  op;
    logic mult_en;
    logic label_en;
    logic last_item;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic rda_zero;
    logic div_done;
  } sts_t;

endpackage

>>> rtl/lupiv_div.sv
// lupiv_div: restoring divider, one quotient bit per cycle, for the multipliers
// depends on lupiv_pkg
module lupiv_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [31:0]          num,
  input  logic signed [31:0]          den,
  output logic                        done,
  output logic                        neg,
  output logic [lupiv_pkg::DIV_W-1:0] quo
);
  import lupiv_pkg::*;

  logic [DIV_W-1:0]  dq;
  logic [31:0]       rem;
  logic [31:0]       dmag;
  logic [DIV_CW-1:0] cnt;
  logic              run;
  logic [32:0]       trial;
  logic              ge;
  logic [31:0]       nmag;

  // magnitude of the numerator
  assign nmag  = num[31] ? (~num + 32'd1) : num;
  // one restoring step
  assign trial = {rem, dq[DIV_W-1]};
  assign ge    = trial >= {1'b0, dmag};
  assign quo   = dq;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CW'(DIV_W);
      end else if (run) begin
        cnt <= cnt - DIV_CW'(1);
        if (cnt == DIV_CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dq   <= {nmag, 16'd0};
      rem  <= '0;
      dmag <= den[31] ? (~den + 32'd1) : den;
      neg  <= num[31] ^ den[31];
    end else if (run) begin
      rem <= ge ? 32'(trial - {1'b0, dmag}) : trial[31:0];
      dq  <= {dq[DIV_W-2:0], ge};
    end
  end

endmodule

>>> rtl/lupiv_dp.sv
// lupiv_dp: datapath with matrix, multiplier and label memories, arithmetic and flags
// depends on lupiv_pkg and lupiv_div
module lupiv_dp #(
  parameter int MAX_SIZE = lupiv_pkg::MAX_SIZE_DEF,
  parameter int IDX_W    = $clog2(MAX_SIZE)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  lupiv_pkg::cmd_t         cmd,
  input  logic [2*IDX_W-1:0]      addr_a,
  input  logic [2*IDX_W-1:0]      addr_b,
  input  logic signed [31:0]      value,
  input  logic [7:0]              row_label,
  output lupiv_pkg::sts_t         sts,
  output logic                    out_valid,
  output logic [2:0]              out_row,
  output logic [2:0]              out_col,
  output logic signed [31:0]      upper_value,
  output logic signed [31:0]      lower_value,
  output logic [7:0]              out_label,
  output logic                    singular,
  output logic                    saturated,
  output logic                    end_of_run
);
  import lupiv_pkg::*;

  localparam int DEPTH = MAX_SIZE << IDX_W;

  logic signed [31:0] mat [DEPTH];
  logic signed [31:0] mlt [DEPTH];
  logic [7:0]         lab [MAX_SIZE];

  logic signed [31:0] rda, rdb, rma, rmb;
  logic [7:0]         rla, rlb;
  logic signed [31:0] pivot;
  logic signed [31:0] mult;
  logic signed [63:0] prod;
  logic               sing_f, sat_f;

  logic [IDX_W-1:0]   row_a, row_b, col_a;
  logic               div_done, div_neg;
  logic [DIV_W-1:0]   quo;

  logic signed [31:0] div_val;
  logic               div_sat;
  logic signed [63:0] prod_adj;
  logic signed [47:0] prod_q;
  logic signed [48:0] diff;
  logic signed [31:0] upd_val;
  logic               upd_sat;

  logic               mat_we, mlt_we, lab_we;
  logic [2*IDX_W-1:0] mat_wa, mlt_wa;
  logic [IDX_W-1:0]   lab_wa;
  logic signed [31:0] mat_wd, mlt_wd;
  logic [7:0]         lab_wd;

  assign row_a = addr_a[2*IDX_W-1:IDX_W];
  assign row_b = addr_b[2*IDX_W-1:IDX_W];
  assign col_a = addr_a[IDX_W-1:0];

  lupiv_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.op == OP_DIV),
    .num   (rda),
    .den   (pivot),
    .done  (div_done),
    .neg   (div_neg),
    .quo   (quo)
  );

  assign sts.rda_zero = (rda == 32'sd0);
  assign sts.div_done = div_done;

  // signed quotient with clamp
  always_comb begin
    div_sat = 1'b0;
    if (!div_neg) begin
      if (quo > DIV_W'(32'h7FFF_FFFF)) begin
        div_sat = 1'b1;
        div_val = 32'sh7FFF_FFFF;
      end else begin
        div_val = quo[31:0];
      end
    end else begin
      if (quo > DIV_W'(32'h8000_0000)) begin
        div_sat = 1'b1;
        div_val = 32'sh8000_0000;
      end else begin
        div_val = ~quo[31:0] + 32'd1;
      end
    end
  end

  // product scaled down toward zero, subtracted and clamped
  always_comb begin
    prod_adj = prod + (prod[63] ? 64'sd65535 : 64'sd0);
    prod_q   = prod_adj[63:16];
    diff     = {{17{rdb[31]}}, rdb} - {prod_q[47], prod_q};
    upd_sat  = 1'b0;
    if (diff > 49'sh0_7FFF_FFFF) begin
      upd_sat = 1'b1;
      upd_val = 32'sh7FFF_FFFF;
    end else if (diff < -49'sh0_8000_0000) begin
      upd_sat = 1'b1;
      upd_val = 32'sh8000_0000;
    end else begin
      upd_val = diff[31:0];
    end
  end

  // write port selection
  always_comb begin
    mat_we = 1'b0;
    mat_wa = addr_a;
    mat_wd = rdb;
    mlt_we = 1'b0;
    mlt_wa = addr_a;
    mlt_wd = rmb;
    lab_we = 1'b0;
    lab_wa = row_a;
    lab_wd = rlb;
    case (cmd.op)
      OP_LOAD: begin
        mat_we = 1'b1;
        mat_wd = value;
        lab_we = cmd.label_en;
        lab_wd = row_label;
      end
      OP_SWAP_A: begin
        mat_we = 1'b1;
        mlt_we = cmd.mult_en;
        lab_we = cmd.label_en;
      end
      OP_SWAP_B: begin
        mat_we = 1'b1;
        mat_wa = addr_b;
        mat_wd = rda;
        mlt_we = cmd.mult_en;
        mlt_wa = addr_b;
        mlt_wd = rma;
        lab_we = cmd.label_en;
        lab_wa = row_b;
        lab_wd = rla;
      end
      // store the multiplier and clear the eliminated entry below the pivot
      OP_WR_MULT: begin
        mlt_we = 1'b1;
        mlt_wd = div_val;
        mat_we = 1'b1;
        mat_wd = 32'sd0;
      end
      OP_WR_ZERO: begin
        mlt_we = 1'b1;
        mlt_wd = 32'sd0;
      end
      OP_UPD: begin
        mat_we = 1'b1;
        mat_wa = addr_b;
        mat_wd = upd_val;
      end
      default: begin
        mat_we = 1'b0;
      end
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (mat_we) mat[mat_wa] <= mat_wd;
    if (mlt_we) mlt[mlt_wa] <= mlt_wd;
    if (lab_we) lab[lab_wa] <= lab_wd;
    if (cmd.op == OP_READ) begin
      rda <= mat[addr_a];
      rdb <= mat[addr_b];
      rma <= mlt[addr_a];
      rmb <= mlt[addr_b];
      rla <= lab[row_a];
      rlb <= lab[row_b];
    end
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_PIVOT) pivot <= rda;
    if (cmd.op == OP_WR_MULT) mult <= div_val;
    if (cmd.op == OP_MUL) prod <= mult * rda;
  end

  // run flags
  always_ff @(posedge clk) begin
    if (rst) begin
      sing_f <= 1'b0;
      sat_f  <= 1'b0;
    end else if (cmd.op == OP_CLEAR) begin
      sing_f <= 1'b0;
      sat_f  <= 1'b0;
    end else begin
      if (cmd.op == OP_SET_SING) sing_f <= 1'b1;
      if (cmd.op == OP_WR_MULT && div_sat) sat_f <= 1'b1;
      if (cmd.op == OP_UPD && upd_sat) sat_f <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= (cmd.op == OP_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      out_row     <= 3'(row_a);
      out_col     <= 3'(col_a);
      upper_value <= (col_a >= row_a) ? rda : 32'sd0;
      lower_value <= (col_a == row_a) ? Q_ONE : ((col_a < row_a) ? rma : 32'sd0);
      out_label   <= rla;
      singular    <= sing_f;
      saturated   <= sat_f;
      end_of_run  <= cmd.last_item;
    end
  end

`ifndef NO_ASSERTIONS
  a_div_not_instant: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DIV |=> !div_done) else $error("divider finished too early");
  a_clear_flags: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_CLEAR |=> !sing_f && !sat_f) else $error("flags not cleared");
  a_emit_strobe: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT |=> out_valid) else $error("result strobe missing");
`endif

endmodule

>>> rtl/lupiv_ctrl.sv
// lupiv_ctrl: controller state machine sequencing load, pivot search, swaps,
// elimination and result output; depends on lupiv_pkg
module lupiv_ctrl #(
  parameter int MAX_SIZE = lupiv_pkg::MAX_SIZE_DEF,
  parameter int IDX_W    = $clog2(MAX_SIZE)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [2:0]         row,
  input  logic [2:0]         col,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  input  lupiv_pkg::sts_t    sts,
  output logic               busy,
  output lupiv_pkg::cmd_t    cmd,
  output logic [2*IDX_W-1:0] addr_a,
  output logic [2*IDX_W-1:0] addr_b
);
  import lupiv_pkg::*;

  localparam int NW = $clog2(MAX_SIZE + 1);

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_CLEAR    = 5'd1;
  localparam logic [4:0] S_PIV_RD   = 5'd2;
  localparam logic [4:0] S_PIV_CHK  = 5'd3;
  localparam logic [4:0] S_SRCH_RD  = 5'd4;
  localparam logic [4:0] S_SRCH_CHK = 5'd5;
  localparam logic [4:0] S_ZERO     = 5'd6;
  localparam logic [4:0] S_SWP_RD   = 5'd7;
  localparam logic [4:0] S_SWP_A    = 5'd8;
  localparam logic [4:0] S_SWP_B    = 5'd9;
  localparam logic [4:0] S_M_RD     = 5'd10;
  localparam logic [4:0] S_DIV      = 5'd11;
  localparam logic [4:0] S_DIV_WAIT = 5'd12;
  localparam logic [4:0] S_E_RD     = 5'd13;
  localparam logic [4:0] S_E_MUL    = 5'd14;
  localparam logic [4:0] S_E_UPD    = 5'd15;
  localparam logic [4:0] S_NEXT_COL = 5'd16;
  localparam logic [4:0] S_OUT_RD   = 5'd17;
  localparam logic [4:0] S_OUT_EM   = 5'd18;

  logic [4:0]       state, state_next;
  logic [3:0]       matrix_size;
  logic [NW-1:0]    n;
  logic [IDX_W-1:0] nm1, nm2;
  logic [IDX_W-1:0] i, h, j, u, k;
  logic [IDX_W-1:0] i_next, h_next, j_next, u_next, k_next;
  logic             in_rng;

  // size register
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_we) begin
      matrix_size <= cfg_data;
    end
  end

  // size in use, clamped
  always_comb begin
    if (int'(matrix_size) < 2) begin
      n = NW'(2);
    end else if (int'(matrix_size) > MAX_SIZE) begin
      n = NW'(MAX_SIZE);
    end else begin
      n = NW'(matrix_size);
    end
    nm1 = IDX_W'(n - NW'(1));
    nm2 = IDX_W'(n - NW'(2));
  end

  assign in_rng = ({{NW{1'b0}}, row} < {3'b000, n}) && ({{NW{1'b0}}, col} < {3'b000, n});
  assign busy   = (state != S_IDLE);

  // sequencing
  always_comb begin
    state_next = state;
    i_next = i;
    h_next = h;
    j_next = j;
    u_next = u;
    k_next = k;
    cmd    = '0;
    cmd.op = OP_NOP;
    addr_a = '0;
    addr_b = '0;
    case (state)
      S_IDLE: begin
        addr_a = {IDX_W'(row), IDX_W'(col)};
        if (start) begin
          if (in_rng) begin
            cmd.op       = OP_LOAD;
            cmd.label_en = (col == 3'd0);
          end
          if (last) state_next = S_CLEAR;
        end
      end
      S_CLEAR: begin
        cmd.op     = OP_CLEAR;
        i_next     = '0;
        state_next = S_PIV_RD;
      end
      S_PIV_RD: begin
        cmd.op     = OP_READ;
        addr_a     = {i, i};
        state_next = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        if (!sts.rda_zero) begin
          cmd.op     = OP_PIVOT;
          h_next     = i + IDX_W'(1);
          state_next = S_M_RD;
        end else begin
          u_next     = i + IDX_W'(1);
          state_next = S_SRCH_RD;
        end
      end
      S_SRCH_RD: begin
        cmd.op     = OP_READ;
        addr_a     = {u, i};
        state_next = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        if (!sts.rda_zero) begin
          k_next     = '0;
          state_next = S_SWP_RD;
        end else if (u == nm1) begin
          cmd.op     = OP_SET_SING;
          h_next     = i + IDX_W'(1);
          state_next = S_ZERO;
        end else begin
          u_next     = u + IDX_W'(1);
          state_next = S_SRCH_RD;
        end
      end
      // skipped column keeps zero multipliers
      S_ZERO: begin
        cmd.op = OP_WR_ZERO;
        addr_a = {h, i};
        if (h == nm1) begin
          state_next = S_NEXT_COL;
        end else begin
          h_next = h + IDX_W'(1);
        end
      end
      S_SWP_RD: begin
        cmd.op     = OP_READ;
        addr_a     = {i, k};
        addr_b     = {u, k};
        state_next = S_SWP_A;
      end
      S_SWP_A: begin
        cmd.op       = OP_SWAP_A;
        cmd.mult_en  = (k < i);
        cmd.label_en = (k == '0);
        addr_a       = {i, k};
        addr_b       = {u, k};
        state_next   = S_SWP_B;
      end
      S_SWP_B: begin
        cmd.op       = OP_SWAP_B;
        cmd.mult_en  = (k < i);
        cmd.label_en = (k == '0);
        addr_a       = {i, k};
        addr_b       = {u, k};
        if (k == nm1) begin
          state_next = S_PIV_RD;
        end else begin
          k_next     = k + IDX_W'(1);
          state_next = S_SWP_RD;
        end
      end
      S_M_RD: begin
        cmd.op     = OP_READ;
        addr_a     = {h, i};
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.op     = OP_DIV;
        state_next = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.op     = OP_WR_MULT;
          addr_a     = {h, i};
          j_next     = i + IDX_W'(1);
          state_next = S_E_RD;
        end
      end
      S_E_RD: begin
        cmd.op     = OP_READ;
        addr_a     = {i, j};
        addr_b     = {h, j};
        state_next = S_E_MUL;
      end
      S_E_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_E_UPD;
      end
      S_E_UPD: begin
        cmd.op = OP_UPD;
        addr_b = {h, j};
        if (j == nm1) begin
          if (h == nm1) begin
            state_next = S_NEXT_COL;
          end else begin
            h_next     = h + IDX_W'(1);
            state_next = S_M_RD;
          end
        end else begin
          j_next     = j + IDX_W'(1);
          state_next = S_E_RD;
        end
      end
      S_NEXT_COL: begin
        if (i == nm2) begin
          h_next     = '0;
          j_next     = '0;
          state_next = S_OUT_RD;
        end else begin
          i_next     = i + IDX_W'(1);
          state_next = S_PIV_RD;
        end
      end
      S_OUT_RD: begin
        cmd.op     = OP_READ;
        addr_a     = {h, j};
        state_next = S_OUT_EM;
      end
      S_OUT_EM: begin
        cmd.op        = OP_EMIT;
        cmd.last_item = (h == nm1) && (j == nm1);
        addr_a        = {h, j};
        if (cmd.last_item) begin
          state_next = S_IDLE;
        end else begin
          if (j == nm1) begin
            j_next = '0;
            h_next = h + IDX_W'(1);
          end else begin
            j_next = j + IDX_W'(1);
          end
          state_next = S_OUT_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    i <= i_next;
    h <= h_next;
    j <= j_next;
    u <= u_next;
    k <= k_next;
  end

`ifndef NO_ASSERTIONS
  a_idle_ops: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> cmd.op == OP_NOP || cmd.op == OP_LOAD)
    else $error("work issued while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_EMIT && cmd.last_item |=> state == S_IDLE)
    else $error("run did not end after final result");
  a_div_to_elim: assert property (@(posedge clk) disable iff (rst)
    state == S_DIV_WAIT && sts.div_done |=> state == S_E_RD)
    else $error("elimination did not follow multiplier");
`endif

endmodule

>>> rtl/lu_decomposition_pivoting_unit.sv
// lu_decomposition_pivoting_unit: top level joining controller and datapath
// depends on lupiv_pkg, lupiv_ctrl, lupiv_dp (and lupiv_div below it)
//
// usage: write the size register with cfg_we/cfg_data while the unit is idle.
// load elements with start while busy is low, one item per cycle; row_label is
// taken from the column zero element of each row, elements outside the size in
// use are dropped. an item with last set starts factorization and raises busy.
// each multiplier needs a read, a divider start and the 48-step serial divider;
// updating a row reads, multiplies and writes back each remaining column; a
// pivot search reads and checks each row tried, and a row exchange reads and
// writes both rows per column. when all columns are done, the n*n results
// follow in row-major order, each read and then emitted, each shown for one
// cycle with out_valid high; end_of_run marks the last one and busy then drops.
// the receiver cannot stall, so results are never held.
// reset returns the unit to idle, clears the flags and sets the size to 8;
// matrix and label contents are undefined until loaded.
module lu_decomposition_pivoting_unit #(
  parameter int MAX_SIZE = lupiv_pkg::MAX_SIZE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         row,
  input  logic [2:0]         col,
  input  logic signed [31:0] value,
  input  logic [7:0]         row_label,
  input  logic               last,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_data,
  output logic               out_valid,
  output logic [2:0]         out_row,
  output logic [2:0]         out_col,
  output logic signed [31:0] upper_value,
  output logic signed [31:0] lower_value,
  output logic [7:0]         out_label,
  output logic               singular,
  output logic               saturated,
  output logic               end_of_run
);
  import lupiv_pkg::*;

  localparam int IDX_W = $clog2(MAX_SIZE);

  cmd_t               cmd;
  sts_t               sts;
  logic [2*IDX_W-1:0] addr_a, addr_b;

  lupiv_ctrl #(
    .MAX_SIZE (MAX_SIZE),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .row      (row),
    .col      (col),
    .last     (last),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .sts      (sts),
    .busy     (busy),
    .cmd      (cmd),
    .addr_a   (addr_a),
    .addr_b   (addr_b)
  );

  lupiv_dp #(
    .MAX_SIZE (MAX_SIZE),
    .IDX_W    (IDX_W)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .addr_a      (addr_a),
    .addr_b      (addr_b),
    .value       (value),
    .row_label   (row_label),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_row     (out_row),
    .out_col     (out_col),
    .upper_value (upper_value),
    .lower_value (lower_value),
    .out_label   (out_label),
    .singular    (singular),
    .saturated   (saturated),
    .end_of_run  (end_of_run)
  );

endmodule
